// ----- src/circle_octant_rasterizer_core_assert.svh -----
// ----------------------------------------------------------------------------
// circle_octant_rasterizer_core assertion macros
// Shorthands for clocked concurrent assertions with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_OCTANT_RASTERIZER_CORE_ASSERT_SVH
`define CIRCLE_OCTANT_RASTERIZER_CORE_ASSERT_SVH

// assertion gated off while reset is high
`define COR_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion that also holds across reset
`define COR_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/cor_pkg.sv -----
// ----------------------------------------------------------------------------
// cor_pkg
// Shared widths, codes and the command type of the circle rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package cor_pkg;

   localparam int COORD_BITS = 10;
   localparam int RAD_BITS   = COORD_BITS - 1;
   localparam int DEC_BITS   = COORD_BITS + 3;
   localparam int PIX_BITS   = COORD_BITS + 2;
   localparam int PHASE_BITS = 3;
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_BITS = 1;
   localparam int FIFO_CNT_BITS = 2;

   localparam logic [PHASE_BITS-1:0] PHASE_LAST = 3'd7;

   localparam logic MODE_START = 1'b0;
   localparam logic MODE_STEP  = 1'b1;

   typedef struct packed {
      logic                  done;
      logic [COORD_BITS-1:0] origin_x;
      logic [COORD_BITS-1:0] origin_y;
      logic [COORD_BITS-1:0] offset_x;
      logic [COORD_BITS-1:0] offset_y;
   } cmd_type;

endpackage

`default_nettype wire

// ----- src/circle_octant_rasterizer_core.sv -----
// ----------------------------------------------------------------------------
// circle_octant_rasterizer_core
// Midpoint circle generator, one octant step per request.
// ----------------------------------------------------------------------------
// A start request (mode 0) loads center and radius into the front registers
// and returns nothing. A step request (mode 1) returns eight pixel beats, one
// per cycle while the output is popped, the eighth flagged last_of_step; once
// the octant is finished each step returns a single done beat. The single
// result register issues one beat per cycle while popped. The front keeps the
// circle state and queues steps in a two-entry queue; a step holds its entry
// until its last pixel loads, so one further step is taken while it drains.
`default_nettype none

module circle_octant_rasterizer_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic                                req_mode,
   input  logic [cor_pkg::COORD_BITS-1:0]      req_center_x,
   input  logic [cor_pkg::COORD_BITS-1:0]      req_center_y,
   input  logic [cor_pkg::RAD_BITS-1:0]        req_radius,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [cor_pkg::PIX_BITS-1:0] rsp_pixel_x,
   output logic signed [cor_pkg::PIX_BITS-1:0] rsp_pixel_y,
   output logic                                rsp_last_of_step,
   output logic                                rsp_done_res
);
   import cor_pkg::*;

   logic    accept;
   logic    cmd_push, cmd_pop, cmd_empty;
   cmd_type cmd_wr, cmd_rd;

   assign accept = req_push && !req_full;

   cor_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .mode     (req_mode),
      .center_x (req_center_x),
      .center_y (req_center_y),
      .radius   (req_radius),
      .cmd_push (cmd_push),
      .cmd      (cmd_wr)
   );

   cor_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata (cmd_wr),
      .pop   (cmd_pop),
      .rdata (cmd_rd),
      .empty (cmd_empty),
      .full  (req_full)
   );

   cor_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd_rd),
      .cmd_empty        (cmd_empty),
      .cmd_pop          (cmd_pop),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_last_of_step (rsp_last_of_step),
      .rsp_done_res     (rsp_done_res)
   );

endmodule

`default_nettype wire

// ----- src/cor_front.sv -----
// ----------------------------------------------------------------------------
// cor_front
// Takes items, keeps the circle state and issues one command per step.
// ----------------------------------------------------------------------------
`default_nettype none

module cor_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          mode,
   input  logic [cor_pkg::COORD_BITS-1:0] center_x,
   input  logic [cor_pkg::COORD_BITS-1:0] center_y,
   input  logic [cor_pkg::RAD_BITS-1:0]   radius,
   output logic                          cmd_push,
   output cor_pkg::cmd_type              cmd
);
   import cor_pkg::*;

   logic [COORD_BITS-1:0]      origin_x_ff, origin_x_in;
   logic [COORD_BITS-1:0]      origin_y_ff, origin_y_in;
   logic [COORD_BITS-1:0]      offset_x_ff, offset_x_in;
   logic [COORD_BITS-1:0]      offset_y_ff, offset_y_in;
   logic signed [DEC_BITS-1:0] decision_ff, decision_in;
   logic                       finished;
   logic [DEC_BITS-1:0]        x4, y4;

   assign finished = (offset_x_ff >= offset_y_ff);
   assign x4 = {1'b0, offset_x_ff, 2'b00};
   assign y4 = {1'b0, offset_y_ff, 2'b00};

   always_comb begin
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      offset_x_in = offset_x_ff;
      offset_y_in = offset_y_ff;
      decision_in = decision_ff;
      cmd_push    = 1'b0;
      cmd.done     = finished;
      cmd.origin_x = origin_x_ff;
      cmd.origin_y = origin_y_ff;
      cmd.offset_x = offset_x_ff;
      cmd.offset_y = offset_y_ff;
      if (accept) begin
         if (mode == MODE_START) begin
            origin_x_in = center_x;
            origin_y_in = center_y;
            offset_x_in = '0;
            offset_y_in = COORD_BITS'(radius);
            decision_in = DEC_BITS'(3) - DEC_BITS'({radius, 1'b0});
         end else begin
            cmd_push = 1'b1;
            if (!finished) begin
               if (decision_ff[DEC_BITS-1]) begin
                  decision_in = decision_ff + x4 + DEC_BITS'(6);
               end else begin
                  decision_in = decision_ff + (x4 - y4) + DEC_BITS'(10);
                  offset_y_in = offset_y_ff - 1'b1;
               end
               offset_x_in = offset_x_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         offset_x_ff <= '0;
         offset_y_ff <= '0;
         decision_ff <= '0;
      end else begin
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         offset_x_ff <= offset_x_in;
         offset_y_ff <= offset_y_in;
         decision_ff <= decision_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/cor_fifo.sv -----
// ----------------------------------------------------------------------------
// cor_fifo
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module cor_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cor_pkg::cmd_type wdata,
   input  logic             pop,
   output cor_pkg::cmd_type rdata,
   output logic             empty,
   output logic             full
);
   import cor_pkg::*;

   cmd_type                  slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;
   logic                     do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == FIFO_CNT_BITS'(FIFO_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + FIFO_CNT_BITS'(do_push) - FIFO_CNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/cor_back.sv -----
// ----------------------------------------------------------------------------
// cor_back
// Expands each command into eight octant pixels or one done beat.
// ----------------------------------------------------------------------------
`default_nettype none

module cor_back (
   input  logic                               clock,
   input  logic                               reset,
   input  cor_pkg::cmd_type                   cmd,
   input  logic                               cmd_empty,
   output logic                               cmd_pop,
   input  logic                               rsp_pop,
   output logic                               rsp_empty,
   output logic signed [cor_pkg::PIX_BITS-1:0] rsp_pixel_x,
   output logic signed [cor_pkg::PIX_BITS-1:0] rsp_pixel_y,
   output logic                               rsp_last_of_step,
   output logic                               rsp_done_res
);
   import cor_pkg::*;

   logic [PHASE_BITS-1:0]      phase_ff, phase_in;
   logic                       valid_ff, valid_in;
   logic signed [PIX_BITS-1:0] pixel_x_ff, pixel_x_in;
   logic signed [PIX_BITS-1:0] pixel_y_ff, pixel_y_in;
   logic                       last_ff, last_in;
   logic                       done_ff, done_in;
   logic                       load, swap, neg_x, neg_y;
   logic [COORD_BITS-1:0]      dx, dy;

   // phase bits pick the octant: swap on 1,2,5,6; negate x on 4..7, y on 2,3,6,7
   assign swap  = phase_ff[0] ^ phase_ff[1];
   assign neg_x = phase_ff[2];
   assign neg_y = phase_ff[1];
   assign dx    = swap ? cmd.offset_y : cmd.offset_x;
   assign dy    = swap ? cmd.offset_x : cmd.offset_y;

   assign load    = !cmd_empty && (!valid_ff || rsp_pop);
   assign cmd_pop = load && (cmd.done || phase_ff == PHASE_LAST);

   always_comb begin
      phase_in   = phase_ff;
      valid_in   = valid_ff && !rsp_pop;
      pixel_x_in = pixel_x_ff;
      pixel_y_in = pixel_y_ff;
      last_in    = last_ff;
      done_in    = done_ff;
      if (load) begin
         valid_in = 1'b1;
         phase_in = cmd_pop ? '0 : phase_ff + 1'b1;
         if (cmd.done) begin
            pixel_x_in = '0;
            pixel_y_in = '0;
            last_in    = 1'b1;
            done_in    = 1'b1;
         end else begin
            pixel_x_in = neg_x ? PIX_BITS'(cmd.origin_x) - PIX_BITS'(dx)
                               : PIX_BITS'(cmd.origin_x) + PIX_BITS'(dx);
            pixel_y_in = neg_y ? PIX_BITS'(cmd.origin_y) - PIX_BITS'(dy)
                               : PIX_BITS'(cmd.origin_y) + PIX_BITS'(dy);
            last_in    = (phase_ff == PHASE_LAST);
            done_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
      pixel_x_ff <= pixel_x_in;
      pixel_y_ff <= pixel_y_in;
      last_ff    <= last_in;
      done_ff    <= done_in;
   end

   assign rsp_empty        = !valid_ff;
   assign rsp_pixel_x      = pixel_x_ff;
   assign rsp_pixel_y      = pixel_y_ff;
   assign rsp_last_of_step = last_ff;
   assign rsp_done_res     = done_ff;

endmodule

`default_nettype wire

// ----- src/cor_checker.sv -----
// ----------------------------------------------------------------------------
// cor_checker
// Port-level checks on the circle rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "circle_octant_rasterizer_core_assert.svh"

module cor_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_full,
   input logic                                rsp_empty,
   input logic                                rsp_pop,
   input logic signed [cor_pkg::PIX_BITS-1:0] rsp_pixel_x,
   input logic signed [cor_pkg::PIX_BITS-1:0] rsp_pixel_y,
   input logic                                rsp_last_of_step,
   input logic                                rsp_done_res
);

   `COR_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> rsp_empty && !req_full, "not idle after reset")

   `COR_ASSERT(a_done_shape, clock, reset, !rsp_empty && rsp_done_res |-> rsp_last_of_step && rsp_pixel_x == 0 && rsp_pixel_y == 0, "done beat carries pixel")

   `COR_ASSERT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_pixel_x) && $stable(rsp_pixel_y), "stalled beat changed")

endmodule

bind circle_octant_rasterizer_core cor_checker u_cor_checker (.*);

`default_nettype wire

// ----- test/circle_octant_rasterizer_core_tb.sv -----
// ----------------------------------------------------------------------------
// circle_octant_rasterizer_core_tb
// Self-checking bench for the midpoint circle core. A scoreboard model
// tracks origin, offsets and decision term, predicts the pixel beats of
// every accepted step and checks each popped beat against them. Stimulus
// runs directed corner cases, a long output stall and random circles.
// ----------------------------------------------------------------------------
module circle_octant_rasterizer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cor_pkg::*;

   localparam int IDLE_PCT     = 9;
   localparam int RANDOM_ITEMS = 126;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 32;
   localparam int LIMIT_CYCLES = 200000;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic signed [PIX_BITS-1:0] x;
      logic signed [PIX_BITS-1:0] y;
      logic                       last;
      logic                       done;
   } pixel_beat_type;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_push;
   logic                         req_full;
   logic                         req_mode;
   logic [COORD_BITS-1:0]        req_center_x;
   logic [COORD_BITS-1:0]        req_center_y;
   logic [RAD_BITS-1:0]          req_radius;
   logic                         rsp_empty;
   logic                         rsp_pop;
   logic signed [PIX_BITS-1:0]   rsp_pixel_x;
   logic signed [PIX_BITS-1:0]   rsp_pixel_y;
   logic                         rsp_last_of_step;
   logic                         rsp_done_res;

   // circle state mirrored by the scoreboard
   logic [COORD_BITS-1:0]        arc_org_x;
   logic [COORD_BITS-1:0]        arc_org_y;
   logic [COORD_BITS-1:0]        arc_off_x;
   logic [COORD_BITS-1:0]        arc_off_y;
   logic signed [DEC_BITS-1:0]   arc_decision;

   pixel_beat_type               expected_pixels[$];
   int                           mismatch_count = 0;
   int                           cycle_count = 0;
   int                           gap_pct = IDLE_PCT;
   int                           hold_request = 0;

   circle_octant_rasterizer_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_mode         (req_mode),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_radius       (req_radius),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_last_of_step (rsp_last_of_step),
      .rsp_done_res     (rsp_done_res)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("circle_octant_rasterizer_core_tb failed");
         $finish;
      end
   end

   function automatic void push_pixel(input int px, input int py, input logic last);
      pixel_beat_type beat;
      beat.x    = PIX_BITS'(px);
      beat.y    = PIX_BITS'(py);
      beat.last = last;
      beat.done = 1'b0;
      expected_pixels.push_back(beat);
   endfunction

   // start loads the circle; step emits one octant's eight mirrored pixels, or a done beat once finished
   function automatic void trace_octant_step(input logic mode,
                                             input logic [COORD_BITS-1:0] cx,
                                             input logic [COORD_BITS-1:0] cy,
                                             input logic [RAD_BITS-1:0] rad);
      int             ox;
      int             oy;
      int             x;
      int             y;
      pixel_beat_type beat;
      if (mode == MODE_START) begin
         arc_org_x    = cx;
         arc_org_y    = cy;
         arc_off_x    = '0;
         arc_off_y    = COORD_BITS'(rad);
         arc_decision = DEC_BITS'(3 - 2 * int'(rad));
         return;
      end
      if (arc_off_x >= arc_off_y) begin
         beat.x    = '0;
         beat.y    = '0;
         beat.last = 1'b1;
         beat.done = 1'b1;
         expected_pixels.push_back(beat);
         return;
      end
      ox = int'(arc_org_x);
      oy = int'(arc_org_y);
      x  = int'(arc_off_x);
      y  = int'(arc_off_y);
      push_pixel(ox + x, oy + y, 1'b0);
      push_pixel(ox + y, oy + x, 1'b0);
      push_pixel(ox + y, oy - x, 1'b0);
      push_pixel(ox + x, oy - y, 1'b0);
      push_pixel(ox - x, oy + y, 1'b0);
      push_pixel(ox - y, oy + x, 1'b0);
      push_pixel(ox - y, oy - x, 1'b0);
      push_pixel(ox - x, oy - y, 1'b1);
      if (arc_decision < 0) begin
         arc_decision = DEC_BITS'(int'(arc_decision) + 4 * x + 6);
      end else begin
         arc_decision = DEC_BITS'(int'(arc_decision) + 4 * (x - y) + 10);
         arc_off_y    = arc_off_y - 1'b1;
      end
      arc_off_x = arc_off_x + 1'b1;
   endfunction

   // push stays high after a beat; it is lowered only in idle gaps and at the end of stimulus
   task automatic send_request(input logic mode,
                               input logic [COORD_BITS-1:0] cx,
                               input logic [COORD_BITS-1:0] cy,
                               input logic [RAD_BITS-1:0] rad);
      while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push     <= 1'b1;
      req_mode     <= mode;
      req_center_x <= cx;
      req_center_y <= cy;
      req_radius   <= rad;
      @(posedge clock);
      while (req_full) @(posedge clock);
      trace_octant_step(mode, cx, cy, rad);
   endtask

   task automatic send_start(input logic [COORD_BITS-1:0] cx,
                             input logic [COORD_BITS-1:0] cy,
                             input logic [RAD_BITS-1:0] rad);
      send_request(MODE_START, cx, cy, rad);
   endtask

   task automatic send_step();
      send_request(MODE_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                   RAD_BITS'($urandom));
   endtask

   task automatic log_mismatch(input string why, input pixel_beat_type want,
                               input pixel_beat_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s exp x=%0d y=%0d last=%0b done=%0b got x=%0d y=%0d last=%0b done=%0b",
                  $realtime, why, want.x, want.y, want.last, want.done,
                  got.x, got.y, got.last, got.done);
   endtask

   initial begin : rsp_side
      int             hold_left;
      pixel_beat_type got;
      pixel_beat_type want;
      hold_left = 0;
      rsp_pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            got.x    = rsp_pixel_x;
            got.y    = rsp_pixel_y;
            got.last = rsp_last_of_step;
            got.done = rsp_done_res;
            if (expected_pixels.size() == 0) begin
               want = '0;
               log_mismatch("unexpected beat", want, got);
            end else begin
               want = expected_pixels.pop_front();
               if (got.x !== want.x || got.y !== want.y ||
                   got.last !== want.last || got.done !== want.done)
                  log_mismatch("beat mismatch", want, got);
            end
         end
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (reset) begin
            rsp_pop <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= !(gap_pct != 0 && $urandom_range(99) < gap_pct);
         end
      end
   end

   task automatic test_step_before_start();
      send_step();
      send_step();
   endtask

   task automatic test_radius_zero();
      send_start(COORD_BITS'($urandom), COORD_BITS'($urandom), '0);
      send_step();
   endtask

   task automatic test_radius_one();
      send_start(COORD_BITS'(512), COORD_BITS'(512), RAD_BITS'(1));
      send_step();
      send_step();
      send_step();
   endtask

   task automatic test_coordinate_extremes();
      send_start('0, '0, '1);
      repeat (3) send_step();
      send_start('1, '1, '1);
      repeat (3) send_step();
      send_start('1, '0, '1);
      repeat (3) send_step();
   endtask

   task automatic test_full_small_circle();
      send_start(COORD_BITS'(300), COORD_BITS'(700), RAD_BITS'(4));
      while (arc_off_x < arc_off_y) send_step();
      send_step();
   endtask

   task automatic test_output_stall();
      hold_request = HOLD_CYCLES;
      send_start(COORD_BITS'($urandom), COORD_BITS'($urandom), RAD_BITS'(40));
      repeat (8) send_step();
   endtask

   task automatic test_random_circles();
      int                  sent;
      int                  steps;
      int                  cap;
      logic [RAD_BITS-1:0] rad;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         gap_pct = (sent >= RANDOM_ITEMS / 3 && sent < RANDOM_ITEMS * 2 / 3) ? 0 : IDLE_PCT;
         if ($urandom_range(99) < 15) begin
            // noise: unstructured mix of starts and steps
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(1) == 1)
                  send_step();
               else
                  send_start(COORD_BITS'($urandom), COORD_BITS'($urandom),
                             RAD_BITS'($urandom));
               sent++;
            end
         end else begin
            rad = ($urandom_range(11) == 0) ? RAD_BITS'($urandom)
                                            : RAD_BITS'($urandom_range(20));
            send_start(COORD_BITS'($urandom), COORD_BITS'($urandom), rad);
            sent++;
            cap   = $urandom_range(10, 40);
            steps = 0;
            while (arc_off_x < arc_off_y && steps < cap && sent < RANDOM_ITEMS) begin
               send_step();
               steps++;
               sent++;
            end
            repeat ($urandom_range(2)) begin
               send_step();
               sent++;
            end
         end
      end
      gap_pct = IDLE_PCT;
   endtask

   initial begin
      reset        <= 1'b1;
      req_push     <= 1'b0;
      req_mode     <= MODE_START;
      req_center_x <= '0;
      req_center_y <= '0;
      req_radius   <= '0;
      arc_org_x    = '0;
      arc_org_y    = '0;
      arc_off_x    = '0;
      arc_off_y    = '0;
      arc_decision = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_step_before_start();
      test_radius_zero();
      test_radius_one();
      test_coordinate_extremes();
      test_full_small_circle();
      test_output_stall();
      test_random_circles();

      req_push <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("circle_octant_rasterizer_core_tb passed");
      else
         $display("circle_octant_rasterizer_core_tb failed");
      $finish;
   end

endmodule
